/* rtl/dosing_thermostat_pump_controller_core_defines.svh */
// Assertion macros used by the dosing controller checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DOSING_THERMOSTAT_PUMP_CONTROLLER_CORE_DEFINES_SVH
`define DOSING_THERMOSTAT_PUMP_CONTROLLER_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define DTPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Overlapping implication checked outside reset.
`define DTPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define DTPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dtpc_pkg.sv */
// Types and constants of the dosing, thermostat and pump controller.
// No dependencies; used by the register file, controller and top level, and by the testbench.
`default_nettype none

package dtpc_pkg;

    localparam int PUMP_COUNT = 3;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_PUMP   = 2'd2
    } dtpc_req_t;

    localparam logic [1:0] PICK_ACID = 2'd0;
    localparam logic [1:0] PICK_BASE = 2'd1;
    localparam logic [1:0] PICK_FEED = 2'd2;
    localparam logic [1:0] PICK_NONE = 2'd3;

    localparam logic [2:0] REG_PH_TARGET     = 3'd0;
    localparam logic [2:0] REG_TEMP_TARGET   = 3'd1;
    localparam logic [2:0] REG_PH_BAND       = 3'd2;
    localparam logic [2:0] REG_TEMP_BAND     = 3'd3;
    localparam logic [2:0] REG_DOSE_LOCKOUT  = 3'd4;
    localparam logic [2:0] REG_FEED_INTERVAL = 3'd5;
    localparam logic [2:0] REG_FEED_LENGTH   = 3'd6;
    localparam logic [2:0] REG_PUMP_LIMIT    = 3'd7;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [13:0] DOSE_MIN = 14'd100;
    localparam logic [13:0] DOSE_MAX = 14'd1000;

    typedef struct packed {
        logic [13:0]        ph_target_milli;
        logic signed [14:0] temp_target_centi;
        logic [10:0]        ph_band_milli;
        logic [9:0]         temp_band_centi;
        logic [31:0]        dose_lockout_ms;
        logic [31:0]        feed_interval_ms;
        logic [15:0]        feed_length_ms;
        logic [15:0]        pump_limit_ms;
    } dtpc_cfg_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [13:0]        ph_milli;
        logic signed [14:0] temp_centi;
        logic               sample_bad;
        logic [1:0]         pump_pick;
        logic [15:0]        run_ms;
    } dtpc_item_t;

    typedef struct packed {
        logic fault;
        logic stirrer_on;
        logic heater_on;
        logic feed_on;
        logic base_on;
        logic acid_on;
    } dtpc_flags_t;

endpackage

`default_nettype wire

/* rtl/dtpc_cfg_regs.sv */
// Configuration register file of the dosing controller.
// Depends on dtpc_pkg.
`default_nettype none

module dtpc_cfg_regs (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [dtpc_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [dtpc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    output dtpc_pkg::dtpc_cfg_t                         cfg
);
    import dtpc_pkg::*;

    dtpc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ph_target_milli   <= 14'd7000;
            cfg_reg.temp_target_centi <= 15'sd3700;
            cfg_reg.ph_band_milli     <= 11'd100;
            cfg_reg.temp_band_centi   <= 10'd50;
            cfg_reg.dose_lockout_ms   <= 32'd60000;
            cfg_reg.feed_interval_ms  <= 32'd3600000;
            cfg_reg.feed_length_ms    <= 16'd5000;
            cfg_reg.pump_limit_ms     <= 16'd10000;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PH_TARGET:     cfg_reg.ph_target_milli   <= cfg_wdata[13:0];
                REG_TEMP_TARGET:   cfg_reg.temp_target_centi <= $signed(cfg_wdata[14:0]);
                REG_PH_BAND:       cfg_reg.ph_band_milli     <= cfg_wdata[10:0];
                REG_TEMP_BAND:     cfg_reg.temp_band_centi   <= cfg_wdata[9:0];
                REG_DOSE_LOCKOUT:  cfg_reg.dose_lockout_ms   <= cfg_wdata[31:0];
                REG_FEED_INTERVAL: cfg_reg.feed_interval_ms  <= cfg_wdata[31:0];
                REG_FEED_LENGTH:   cfg_reg.feed_length_ms    <= cfg_wdata[15:0];
                REG_PUMP_LIMIT:    cfg_reg.pump_limit_ms     <= cfg_wdata[15:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/dtpc_ctrl.sv */
// Controller state (clock, pump timers, dose/feed stamps, heater, fault)
// and its single-pass update per transaction. Depends on dtpc_pkg.
`default_nettype none

module dtpc_ctrl #(
    parameter int TIME_BITS = 32,
    parameter int RUN_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  dtpc_pkg::dtpc_item_t      item,
    input  dtpc_pkg::dtpc_cfg_t       cfg,
    output dtpc_pkg::dtpc_flags_t     flags
);
    import dtpc_pkg::*;

    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int LW = (RUN_BITS > 16) ? RUN_BITS : 16;

    logic [TIME_BITS-1:0] time_now_reg,  time_now_next;
    logic [TIME_BITS-1:0] last_dose_reg, last_dose_next;
    logic [TIME_BITS-1:0] last_feed_reg, last_feed_next;
    logic [PUMP_COUNT-1:0] active_reg,   active_next;
    logic [RUN_BITS-1:0]  left_reg  [PUMP_COUNT];
    logic [RUN_BITS-1:0]  left_next [PUMP_COUNT];
    logic heat_state_reg, heat_state_next;
    logic heater_reg,     heater_next;
    logic fault_reg,      fault_next;

    logic [TIME_BITS-1:0] dose_gap, feed_gap;
    logic                 lockout_ok, feed_due;
    logic signed [14:0]   ph_err;
    logic [13:0]          ph_mag;
    logic [13:0]          dose_amt;
    logic [1:0]           dose_pump;
    logic                 dose_go;
    logic signed [16:0]   temp_x, temp_hi, temp_lo, tgt_x, band_x;
    logic [RUN_BITS-1:0]  dose_len, feed_len, man_len;

    // Clamp to the pump limit, then saturate to the timer width.
    function automatic logic [RUN_BITS-1:0] run_clamp(input logic [15:0] len,
                                                       input logic [15:0] lim);
        logic [15:0]   l;
        logic [LW-1:0] w;
        l = (len > lim) ? lim : len;
        w = LW'(l);
        if (w > LW'({RUN_BITS{1'b1}}))
            w = LW'({RUN_BITS{1'b1}});
        return w[RUN_BITS-1:0];
    endfunction

    always_comb
    begin
        dose_gap   = time_now_reg - last_dose_reg;
        feed_gap   = time_now_reg - last_feed_reg;
        lockout_ok = CW'(dose_gap) >= CW'(cfg.dose_lockout_ms);
        feed_due   = CW'(feed_gap) >  CW'(cfg.feed_interval_ms);

        ph_err = $signed({1'b0, item.ph_milli}) - $signed({1'b0, cfg.ph_target_milli});
        ph_mag = ph_err[14] ? 14'(-ph_err) : ph_err[13:0];
        if (ph_mag < DOSE_MIN)
            dose_amt = DOSE_MIN;
        else if (ph_mag > DOSE_MAX)
            dose_amt = DOSE_MAX;
        else
            dose_amt = ph_mag;
        dose_pump = (ph_err > 15'sd0) ? PICK_ACID : PICK_BASE;
        dose_go   = lockout_ok && (ph_mag >= 14'(cfg.ph_band_milli))
                    && !active_reg[dose_pump];

        temp_x  = {{2{item.temp_centi[14]}}, item.temp_centi};
        tgt_x   = {{2{cfg.temp_target_centi[14]}}, cfg.temp_target_centi};
        band_x  = $signed({7'd0, cfg.temp_band_centi});
        temp_hi = tgt_x + band_x;
        temp_lo = tgt_x - band_x;

        dose_len = run_clamp({2'd0, dose_amt}, cfg.pump_limit_ms);
        feed_len = run_clamp(cfg.feed_length_ms, cfg.pump_limit_ms);
        man_len  = run_clamp(item.run_ms, cfg.pump_limit_ms);
    end

    always_comb
    begin
        time_now_next   = time_now_reg;
        last_dose_next  = last_dose_reg;
        last_feed_next  = last_feed_reg;
        active_next     = active_reg;
        left_next       = left_reg;
        heat_state_next = heat_state_reg;
        heater_next     = heater_reg;
        fault_next      = fault_reg;

        case (item.req_type)
            REQ_TICK:
            begin
                time_now_next = time_now_reg + TIME_BITS'(1);
                for (int i = 0; i < PUMP_COUNT; i++)
                begin
                    if (active_reg[i] && (left_reg[i] != '0))
                        left_next[i] = left_reg[i] - RUN_BITS'(1);
                end
            end
            REQ_SAMPLE:
            begin
                if (item.sample_bad)
                begin
                    fault_next  = 1'b1;
                    active_next = '0;
                    for (int i = 0; i < PUMP_COUNT; i++)
                        left_next[i] = '0;
                    heater_next = 1'b0;
                end
                else
                begin
                    fault_next = 1'b0;
                    if (dose_go)
                    begin
                        active_next[dose_pump] = 1'b1;
                        left_next[dose_pump]   = dose_len;
                        last_dose_next         = time_now_reg;
                    end
                    if (heat_state_reg)
                    begin
                        if (temp_x > temp_hi)
                            heat_state_next = 1'b0;
                    end
                    else if (temp_x < temp_lo)
                    begin
                        heat_state_next = 1'b1;
                    end
                    heater_next = heat_state_next;
                    if (feed_due)
                    begin
                        active_next[PICK_FEED] = 1'b1;
                        left_next[PICK_FEED]   = feed_len;
                        last_feed_next         = time_now_reg;
                    end
                end
            end
            REQ_PUMP:
            begin
                if (item.pump_pick != PICK_NONE)
                begin
                    active_next[item.pump_pick] = 1'b1;
                    left_next[item.pump_pick]   = man_len;
                end
            end
            default:
            begin
                time_now_next = time_now_reg;
            end
        endcase

        for (int i = 0; i < PUMP_COUNT; i++)
        begin
            if (active_next[i] && (left_next[i] == '0))
                active_next[i] = 1'b0;
        end

        flags.acid_on    = active_next[PICK_ACID];
        flags.base_on    = active_next[PICK_BASE];
        flags.feed_on    = active_next[PICK_FEED];
        flags.heater_on  = heater_next;
        flags.stirrer_on = !fault_next;
        flags.fault      = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg   <= '0;
            last_dose_reg  <= '0;
            last_feed_reg  <= '0;
            active_reg     <= '0;
            for (int i = 0; i < PUMP_COUNT; i++)
                left_reg[i] <= '0;
            heat_state_reg <= 1'b0;
            heater_reg     <= 1'b0;
            fault_reg      <= 1'b0;
        end
        else if (step)
        begin
            time_now_reg   <= time_now_next;
            last_dose_reg  <= last_dose_next;
            last_feed_reg  <= last_feed_next;
            active_reg     <= active_next;
            left_reg       <= left_next;
            heat_state_reg <= heat_state_next;
            heater_reg     <= heater_next;
            fault_reg      <= fault_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dosing_thermostat_pump_controller_core.sv */
// channel  | signals                           | payload
// s        | s_tvalid s_tready s_tuser s_tdata | request kind, sample, manual start
// m        | m_tvalid m_tready m_tdata         | pump, heater, stirrer, fault flags
// cfg      | cfg_we cfg_addr cfg_wdata         | eight set-point/timing registers
//
// One transaction per cycle sustained while m_tready stays high; m_tvalid rises
// after the s accept (input register, then result register after one pass of logic).
// s_tready drops only while both registers are full and m_tready is low.
// Asynchronous active-low reset restores the register defaults, clears time,
// pump timers, heater and fault. No clearing pass is needed.
// Top level of the dosing controller; depends on dtpc_pkg, dtpc_cfg_regs, dtpc_ctrl.
`default_nettype none

module dosing_thermostat_pump_controller_core #(
    parameter int TIME_BITS = 32,
    parameter int RUN_BITS  = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [1:0]                           s_tuser,   // req_type
    // ph_milli[13:0] temp_centi[28:14] sample_bad[29] pump_pick[31:30] run_ms[47:32]
    input  wire logic [47:0]                          s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // acid_on[0] base_on[1] feed_on[2] heater_on[3] stirrer_on[4] fault[5] zero[7:6]
    output logic [7:0]                                m_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [dtpc_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [dtpc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import dtpc_pkg::*;

    dtpc_cfg_t   cfg;
    dtpc_item_t  item_reg, item_next;
    dtpc_flags_t flags;
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic [5:0]  out_data_reg;
    logic        advance;
    logic        s_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        item_next.req_type   = s_tuser;
        item_next.ph_milli   = s_tdata[13:0];
        item_next.temp_centi = $signed(s_tdata[28:14]);
        item_next.sample_bad = s_tdata[29];
        item_next.pump_pick  = s_tdata[31:30];
        item_next.run_ms     = s_tdata[47:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
            item_reg <= item_next;
        if (advance)
            out_data_reg <= flags;
    end

    dtpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dtpc_ctrl #(
        .TIME_BITS (TIME_BITS),
        .RUN_BITS  (RUN_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .flags (flags)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

`default_nettype wire

/* rtl/dtpc_checker.sv */
// Port-level checks of the dosing controller top level, bound to it below.
// Depends on the assertion macro header.
`include "dosing_thermostat_pump_controller_core_defines.svh"
`default_nettype none

module dtpc_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [7:0]                         m_tdata
);

    `DTPC_ASSERT_NEXT(a_m_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `DTPC_ASSERT_IMPL(a_stir_fault, clk, rst_n, m_tvalid, m_tdata[4] != m_tdata[5], "stirrer must be the inverse of fault")
    `DTPC_ASSERT_IMPL(a_fault_heat, clk, rst_n, m_tvalid && m_tdata[5], !m_tdata[3], "heater on during fault")
    `DTPC_ASSERT_IMPL(a_ready_free, clk, rst_n, !m_tvalid, s_tready, "input stalled with empty output")
    `DTPC_ASSERT(a_pad_zero, clk, rst_n, !m_tvalid || (m_tdata[7:6] == 2'b00), "result padding not zero")

endmodule

bind dosing_thermostat_pump_controller_core dtpc_checker u_dtpc_checker (.*);

`default_nettype wire

/* verif/dosing_thermostat_pump_controller_core_test.sv */
// Testbench for the dosing, thermostat and pump controller core: a directed table, then
// random phases under varied settings; results checked vs a predictor or typed flags.
// Depends on dtpc_pkg and dosing_thermostat_pump_controller_core.
`default_nettype none

module dosing_thermostat_pump_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dtpc_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 200;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 162;

    typedef struct {
        bit          is_reg;
        logic [2:0]  idx;
        logic [31:0] val;
        dtpc_item_t  it;
        bit          typed;
        dtpc_flags_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    // predictor state
    dtpc_cfg_t   set_pts;
    logic [31:0] ms_now, dose_stamp, feed_stamp;
    bit          pump_run [PUMP_COUNT];
    logic [15:0] pump_ms [PUMP_COUNT];
    bit          heat_latch, heat_out, fault_seen;

    dtpc_flags_t flags_due[$];
    plan_row_t   plan[$];

    bit src_steady, sink_steady, hold_ask;
    int cycles, mismatches, sent, directed_sent, results_seen, reg_writes;
    int pump_results, heater_results, fault_results;

    always #6 clk = ~clk;

    dosing_thermostat_pump_controller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    function automatic void start_pump(int p, logic [31:0] len);
        if (len > {16'd0, set_pts.pump_limit_ms})
            len = {16'd0, set_pts.pump_limit_ms};
        pump_ms[p]  = len[15:0];
        pump_run[p] = 1'b1;
    endfunction

    function automatic void dose_check(logic [13:0] ph);
        int err, mag, dose, p;
        logic [31:0] since;
        since = ms_now - dose_stamp;
        if (since < set_pts.dose_lockout_ms)
            return;
        err = int'(ph) - int'(set_pts.ph_target_milli);
        mag = (err < 0) ? -err : err;
        if (mag < int'(set_pts.ph_band_milli))
            return;
        dose = (mag < int'(DOSE_MIN)) ? int'(DOSE_MIN) : mag;
        dose = (dose > int'(DOSE_MAX)) ? int'(DOSE_MAX) : dose;
        p = (err > 0) ? int'(PICK_ACID) : int'(PICK_BASE);
        if (!pump_run[p])
        begin
            start_pump(p, 32'(dose));
            dose_stamp = ms_now;
        end
    endfunction

    function automatic void heat_check(int temp);
        int tgt, band;
        tgt  = int'($signed(set_pts.temp_target_centi));
        band = int'(set_pts.temp_band_centi);
        if (heat_latch)
        begin
            if (temp > tgt + band)
                heat_latch = 1'b0;
        end
        else if (temp < tgt - band)
            heat_latch = 1'b1;
        heat_out = heat_latch;
    endfunction

    function automatic void feed_check();
        logic [31:0] since;
        since = ms_now - feed_stamp;
        if (since > set_pts.feed_interval_ms)
        begin
            start_pump(int'(PICK_FEED), {16'd0, set_pts.feed_length_ms});
            feed_stamp = ms_now;
        end
    endfunction

    function automatic dtpc_flags_t step_controller(dtpc_item_t it);
        dtpc_flags_t f;
        case (it.req_type)
            REQ_TICK:
            begin
                ms_now = ms_now + 32'd1;
                for (int p = 0; p < PUMP_COUNT; p++)
                    if (pump_run[p] && pump_ms[p] != 16'd0)
                        pump_ms[p] = pump_ms[p] - 16'd1;
            end
            REQ_SAMPLE:
            begin
                if (it.sample_bad)
                begin
                    fault_seen = 1'b1;
                    for (int p = 0; p < PUMP_COUNT; p++)
                    begin
                        pump_run[p] = 1'b0;
                        pump_ms[p]  = 16'd0;
                    end
                    heat_out = 1'b0;
                end
                else
                begin
                    fault_seen = 1'b0;
                    dose_check(it.ph_milli);
                    heat_check(int'($signed(it.temp_centi)));
                    feed_check();
                end
            end
            REQ_PUMP:
                if (it.pump_pick != PICK_NONE)
                    start_pump(int'(it.pump_pick), {16'd0, it.run_ms});
            default: ;
        endcase
        for (int p = 0; p < PUMP_COUNT; p++)
            if (pump_run[p] && pump_ms[p] == 16'd0)
                pump_run[p] = 1'b0;
        f.acid_on    = pump_run[PICK_ACID];
        f.base_on    = pump_run[PICK_BASE];
        f.feed_on    = pump_run[PICK_FEED];
        f.heater_on  = heat_out;
        f.stirrer_on = !fault_seen;
        f.fault      = fault_seen;
        return f;
    endfunction

    function automatic void apply_setting(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_PH_TARGET:     set_pts.ph_target_milli   = val[13:0];
            REG_TEMP_TARGET:   set_pts.temp_target_centi = val[14:0];
            REG_PH_BAND:       set_pts.ph_band_milli     = val[10:0];
            REG_TEMP_BAND:     set_pts.temp_band_centi   = val[9:0];
            REG_DOSE_LOCKOUT:  set_pts.dose_lockout_ms   = val;
            REG_FEED_INTERVAL: set_pts.feed_interval_ms  = val;
            REG_FEED_LENGTH:   set_pts.feed_length_ms    = val[15:0];
            default:           set_pts.pump_limit_ms     = val[15:0];
        endcase
    endfunction

    function automatic dtpc_item_t request(logic [1:0] kind, int ph, int temp, bit bad,
                                           logic [1:0] pick, int run);
        dtpc_item_t it;
        it.req_type   = kind;
        it.ph_milli   = 14'(ph);
        it.temp_centi = 15'(temp);
        it.sample_bad = bad;
        it.pump_pick  = pick;
        it.run_ms     = 16'(run);
        return it;
    endfunction

    function automatic plan_row_t item_row(logic [1:0] kind, int ph, int temp, bit bad,
                                           logic [1:0] pick, int run, bit typed = 1'b0,
                                           dtpc_flags_t want = '0);
        plan_row_t r;
        r.is_reg = 1'b0;
        r.idx    = '0;
        r.val    = '0;
        r.it     = request(kind, ph, temp, bad, pick, run);
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [2:0] idx, logic [31:0] val);
        plan_row_t r;
        r        = item_row(REQ_TICK, 0, 0, 1'b0, PICK_ACID, 0);
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic logic [31:0] pick_setting(logic [2:0] idx);
        int roll;
        logic [31:0] v;
        roll = $urandom_range(9);
        case (idx)
            REG_PH_TARGET:
                v = (roll == 0) ? 32'd0 : (roll == 1) ? 32'd14000 : 32'($urandom_range(14000));
            REG_TEMP_TARGET:
                v = (roll == 0) ? 32'(-4000) : (roll == 1) ? 32'd12500
                                              : 32'(int'($urandom_range(16500)) - 4000);
            REG_PH_BAND:
                v = (roll == 0) ? 32'd2000 : (roll < 3) ? 32'd0 : 32'($urandom_range(300));
            REG_TEMP_BAND:
                v = (roll == 0) ? 32'd1000 : (roll == 1) ? 32'd0 : 32'($urandom_range(100));
            REG_DOSE_LOCKOUT:
                v = (roll == 0) ? 32'hFFFF_FFFF : (roll == 1) ? 32'($urandom)
                                                 : 32'($urandom_range(40));
            REG_FEED_INTERVAL:
                v = (roll == 0) ? 32'hFFFF_FFFF : (roll == 1) ? 32'($urandom)
                                                 : 32'($urandom_range(60));
            REG_FEED_LENGTH:
                v = (roll == 0) ? 32'd65535 : (roll == 1) ? 32'd0 : 32'($urandom_range(40));
            default:
                v = (roll == 0) ? 32'd65535 : (roll == 1) ? 32'd0 : 32'($urandom_range(60));
        endcase
        return v;
    endfunction

    function automatic dtpc_item_t draw_request();
        int roll, ph, temp, run, w;
        logic [1:0] kind;
        bit bad;
        roll = $urandom_range(99);
        kind = (roll < 45) ? REQ_TICK : (roll < 75) ? REQ_SAMPLE
             : (roll < 93) ? REQ_PUMP : REQ_UNUSED;
        ph   = $urandom_range(14000);
        temp = int'($urandom_range(16500)) - 4000;
        bad  = (kind == REQ_SAMPLE) ? ($urandom_range(9) == 0) : $urandom_range(1);
        if (kind == REQ_SAMPLE && $urandom_range(1))
        begin
            w  = int'(set_pts.ph_band_milli) * 2 + 20;
            ph = int'(set_pts.ph_target_milli) + int'($urandom_range(2 * w)) - w;
            ph = (ph < 0) ? 0 : (ph > 14000) ? 14000 : ph;
            w  = int'(set_pts.temp_band_centi) + 20;
            temp = int'($signed(set_pts.temp_target_centi)) + int'($urandom_range(2 * w)) - w;
            temp = (temp < -4000) ? -4000 : (temp > 12500) ? 12500 : temp;
        end
        roll = $urandom_range(9);
        run  = (roll < 6) ? $urandom_range(30) : (roll < 9) ? $urandom_range(500)
                                               : $urandom_range(65535);
        return request(kind, ph, temp, bad, 2'($urandom_range(3)), run);
    endfunction

    task automatic pace();
        if (!src_steady && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 35);
        end
    endtask

    task automatic send(dtpc_item_t it, bit typed, dtpc_flags_t want);
        dtpc_flags_t f;
        pace();
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {it.run_ms, it.pump_pick, it.sample_bad, it.temp_centi, it.ph_milli};
        do
            @(posedge clk);
        while (!s_tready);
        f = step_controller(it);
        flags_due.push_back(typed ? want : f);
        sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (flags_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        apply_setting(idx, val);
        reg_writes++;
    endtask

    // timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, flags_due.size());
            $display("FAIL dosing_thermostat_pump_controller_core");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        dtpc_flags_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = dtpc_flags_t'(m_tdata[5:0]);
            results_seen++;
            pump_results   += (got.acid_on || got.base_on || got.feed_on);
            heater_results += got.heater_on;
            fault_results  += got.fault;
            if (flags_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction on m: %b", m_tdata);
            end
            else
            begin
                want = flags_due.pop_front();
                if (got !== want || m_tdata[7:6] !== 2'b00)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d mismatch: acid %b/%b base %b/%b feed %b/%b ",
                                  "heater %b/%b stirrer %b/%b fault %b/%b pad %b (exp/act)"},
                                 results_seen, want.acid_on, got.acid_on, want.base_on,
                                 got.base_on, want.feed_on, got.feed_on, want.heater_on,
                                 got.heater_on, want.stirrer_on, got.stirrer_on,
                                 want.fault, got.fault, m_tdata[7:6]);
                end
            end
        end
    end

    // result sink
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_ask = 1'b0;
            end
            else
                m_tready <= sink_steady || ($urandom_range(99) >= 35);
        end
    end

    initial
    begin
        bit reg_open;
        set_pts.ph_target_milli   = 14'd7000;
        set_pts.temp_target_centi = 15'sd3700;
        set_pts.ph_band_milli     = 11'd100;
        set_pts.temp_band_centi   = 10'd50;
        set_pts.dose_lockout_ms   = 32'd60000;
        set_pts.feed_interval_ms  = 32'd3600000;
        set_pts.feed_length_ms    = 16'd5000;
        set_pts.pump_limit_ms     = 16'd10000;
        ms_now = '0;
        dose_stamp = '0;
        feed_stamp = '0;
        for (int p = 0; p < PUMP_COUNT; p++)
        begin
            pump_run[p] = 1'b0;
            pump_ms[p]  = '0;
        end
        heat_latch = 1'b0;
        heat_out   = 1'b0;
        fault_seen = 1'b0;
        reg_open   = 1'b0;

        // flags in the typed column: {fault, stirrer, heater, feed, base, acid}
        plan.push_back(item_row(REQ_TICK,   0, 0, 1'b0, PICK_ACID, 0, 1'b1, 6'b010000));
        plan.push_back(item_row(REQ_UNUSED, 14000, 12500, 1'b1, PICK_NONE, 65535,
                                1'b1, 6'b010000));
        plan.push_back(item_row(REQ_PUMP,   0, 0, 1'b0, PICK_NONE, 65535, 1'b1, 6'b010000));
        plan.push_back(item_row(REQ_PUMP,   0, 0, 1'b0, PICK_ACID, 0, 1'b1, 6'b010000));
        plan.push_back(item_row(REQ_PUMP,   0, 0, 1'b0, PICK_ACID, 65535, 1'b1, 6'b010001));
        plan.push_back(item_row(REQ_PUMP,   0, 0, 1'b0, PICK_BASE, 1, 1'b1, 6'b010011));
        plan.push_back(item_row(REQ_TICK,   0, 0, 1'b0, PICK_ACID, 0, 1'b1, 6'b010001));
        plan.push_back(item_row(REQ_PUMP,   0, 0, 1'b0, PICK_FEED, 3, 1'b1, 6'b010101));
        plan.push_back(item_row(REQ_SAMPLE, 14000, 12500, 1'b1, PICK_ACID, 0,
                                1'b1, 6'b100000));
        plan.push_back(item_row(REQ_PUMP,   0, 0, 1'b0, PICK_ACID, 5, 1'b1, 6'b100001));
        plan.push_back(item_row(REQ_SAMPLE, 7000, 3700, 1'b0, PICK_ACID, 0));
        plan.push_back(item_row(REQ_SAMPLE, 0, -4000, 1'b0, PICK_ACID, 0));
        plan.push_back(item_row(REQ_SAMPLE, 14000, 12500, 1'b0, PICK_ACID, 0));
        plan.push_back(reg_row(REG_DOSE_LOCKOUT, 32'd0));
        // acid still running: no dose
        plan.push_back(item_row(REQ_SAMPLE, 14000, 3700, 1'b0, PICK_ACID, 0));
        plan.push_back(reg_row(REG_FEED_INTERVAL, 32'd0));
        plan.push_back(item_row(REQ_SAMPLE, 0, 3700, 1'b0, PICK_ACID, 0));
        plan.push_back(item_row(REQ_SAMPLE, 7050, 3700, 1'b0, PICK_ACID, 0));
        plan.push_back(item_row(REQ_TICK,   0, 0, 1'b0, PICK_ACID, 0));
        plan.push_back(reg_row(REG_PUMP_LIMIT, 32'd0));
        plan.push_back(item_row(REQ_PUMP,   0, 0, 1'b0, PICK_ACID, 100));
        plan.push_back(reg_row(REG_PH_BAND, 32'd0));
        plan.push_back(reg_row(REG_PH_TARGET, 32'd14000));
        plan.push_back(reg_row(REG_DOSE_LOCKOUT, 32'd3));
        plan.push_back(item_row(REQ_SAMPLE, 14000, 3700, 1'b0, PICK_ACID, 0));
        plan.push_back(item_row(REQ_TICK,   0, 0, 1'b0, PICK_ACID, 0));
        plan.push_back(item_row(REQ_TICK,   0, 0, 1'b0, PICK_ACID, 0));
        plan.push_back(item_row(REQ_SAMPLE, 0, 3700, 1'b0, PICK_ACID, 0));
        plan.push_back(reg_row(REG_TEMP_TARGET, 32'(-4000)));
        plan.push_back(reg_row(REG_TEMP_BAND, 32'd1000));
        plan.push_back(reg_row(REG_FEED_LENGTH, 32'd65535));
        plan.push_back(reg_row(REG_PUMP_LIMIT, 32'd65535));
        plan.push_back(reg_row(REG_FEED_INTERVAL, 32'hFFFF_FFFF));
        plan.push_back(reg_row(REG_DOSE_LOCKOUT, 32'hFFFF_FFFF));
        plan.push_back(reg_row(REG_PH_TARGET, 32'd0));
        plan.push_back(reg_row(REG_PH_BAND, 32'd2000));
        plan.push_back(item_row(REQ_SAMPLE, 14000, -4000, 1'b0, PICK_ACID, 0));
        plan.push_back(item_row(REQ_PUMP,   0, 0, 1'b0, PICK_FEED, 65535));
        plan.push_back(reg_row(REG_TEMP_TARGET, 32'd12500));
        plan.push_back(reg_row(REG_TEMP_BAND, 32'd0));
        plan.push_back(item_row(REQ_SAMPLE, 0, 12499, 1'b0, PICK_ACID, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                if (!reg_open)
                    settle();
                write_reg(plan[i].idx, plan[i].val);
                reg_open = 1'b1;
            end
            else
            begin
                if (reg_open)
                    cfg_we <= 1'b0;
                reg_open = 1'b0;
                send(plan[i].it, plan[i].typed, plan[i].want);
            end
        end
        directed_sent = sent;

        for (int ph_i = 0; ph_i < PHASES; ph_i++)
        begin
            settle();
            for (int r = 0; r < 8; r++)
                if (ph_i == 0 || $urandom_range(1))
                    write_reg(3'(r), pick_setting(3'(r)));
            cfg_we <= 1'b0;
            src_steady  = (ph_i == 2 || ph_i == 5);
            sink_steady = (ph_i == 2);
            // sink backs off while the source keeps pushing
            if (ph_i == 5)
                hold_ask = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send(draw_request(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (flags_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d transactions (%0d directed), %0d register writes, %0d results",
                 sent, directed_sent, reg_writes, results_seen);
        $display("results with a pump on %0d, heater on %0d, fault %0d; mismatches %0d",
                 pump_results, heater_results, fault_results, mismatches);
        if (mismatches == 0)
            $display("PASS dosing_thermostat_pump_controller_core");
        else
            $display("FAIL dosing_thermostat_pump_controller_core");
        $finish;
    end

endmodule

`default_nettype wire
